>>> sv/sobel_nonmax_edge_thinning_macros.svh
// Assertion macros for the edge thinning block
`ifndef SOBEL_NONMAX_EDGE_THINNING_MACROS_SVH
`define SOBEL_NONMAX_EDGE_THINNING_MACROS_SVH
// implication checked on every edge outside reset
`define SNE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sne assertion failed");
// implication checked on the next edge
`define SNE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sne assertion failed");
`endif

>>> sv/sne_pkg.sv
// ----------------------------------------------------------------------------
// sne_pkg
// Shared types, constants and functions of the Sobel edge thinning block.
// ----------------------------------------------------------------------------
package sne_pkg;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam logic [10:0] WIDTH_RESET = 11'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;
  localparam logic [11:0] HEIGHT_MAX = 12'd4095;
  localparam logic [0:0] REG_WIDTH = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_GRAD  = 5'b00100,
    ST_ROOT  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;     // latch pixel, start line reads
    logic grad;     // form gradients, window shift, write lines
    logic root_go;  // one root iteration
    logic finish;   // compute result / update mag state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_grad;   // c>=2 && r>=2
    logic root_done;
  } stat_t;

  // sector from gradients, exact integer tests
  function automatic logic [1:0] sector_of(input logic signed [11:0] gx,
                                           input logic signed [11:0] gy);
    logic [10:0] ax, ay;
    logic [11:0] s;
    logic signed [11:0] d;
    logic [23:0] s2, d2, a2;
    logic [1:0] r;
    ax = gx[11] ? 11'(-gx) : 11'(gx);
    ay = gy[11] ? 11'(-gy) : 11'(gy);
    s = {1'b0, ax} + {1'b0, ay};
    d = $signed({1'b0, ay}) - $signed({1'b0, ax});
    s2 = s * s;
    d2 = 24'(d) * 24'(d);
    a2 = 24'({ax, 1'b0}) * 24'(ax);
    if (ax == 11'd0) r = 2'd2;
    else if (s2 < a2) r = 2'd0;
    else if (ay > ax && d2 > a2) r = 2'd2;
    else if ((gx > 0) == (gy > 0)) r = 2'd1;
    else r = 2'd3;
    return r;
  endfunction
endpackage

>>> sv/sne_ctrl.sv
// ----------------------------------------------------------------------------
// sne_ctrl
// Sequencer: accept pixel, read lines, gradients, bit-serial root, result.
// ----------------------------------------------------------------------------
module sne_ctrl import sne_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  logic  out_busy,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  in_ready
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.take = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_GRAD;
      ST_GRAD: begin
        cmd.grad = 1'b1;
        state_next = stat.has_grad ? ST_ROOT : ST_IDLE;
      end
      ST_ROOT: begin
        cmd.root_go = 1'b1;
        if (stat.root_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

>>> sv/sne_datapath.sv
// ----------------------------------------------------------------------------
// sne_datapath
// Line stores, windows, Sobel sums, root unit and suppression.
// ----------------------------------------------------------------------------
module sne_datapath import sne_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [7:0]  pixel,
  input  logic [10:0] image_width,
  input  logic [11:0] image_height,
  output logic        res_load,
  output logic [7:0]  res_value,
  output logic        res_eor,
  output logic        res_eof
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;

  logic [7:0] pl0 [MAX_WIDTH];
  logic [7:0] pl1 [MAX_WIDTH];
  logic [7:0] ml0 [MAX_WIDTH];
  logic [7:0] ml1 [MAX_WIDTH];
  logic [1:0] sl  [MAX_WIDTH];

  logic [CW-1:0] col, c;
  logic [11:0] row, r;
  logic [CW-1:0] w;
  logic [11:0] h;
  logic [7:0] p;
  logic [7:0] top, mid, mtop, mmid;
  logic [1:0] sl_rd, hold;
  logic [7:0] pw [6];
  logic [7:0] mw [6];
  logic signed [11:0] gx, gy;
  logic [1:0] sec;
  logic [23:0] v;
  logic [7:0] root;
  logic [7:0] rbit;
  logic sat;
  logic [7:0] m;
  logic [CW-1:0] mc;

  // effective bounds
  always_comb begin
    if (image_width < 11'd5) w = CW'(5);
    else if (32'(image_width) > MAX_WIDTH) w = CW'(MAX_WIDTH);
    else w = CW'(image_width);
    h = (image_height < 12'd5) ? 12'd5 : image_height;
  end

  assign mc = c - CW'(2);
  assign stat.has_grad = (c >= CW'(2)) && (r >= 12'd2);
  assign stat.root_done = (rbit == 8'd0);

  // pixel line reads; magnitude line reads at mc
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      p <= pixel;
      c <= (col >= w) ? '0 : col;
      r <= (row >= h) ? '0 : row;
    end
  end

  always_ff @(posedge clk) begin
    top <= pl1[c[AW-1:0]];
    mid <= pl0[c[AW-1:0]];
    mtop <= ml1[mc[AW-1:0]];
    mmid <= ml0[mc[AW-1:0]];
    sl_rd <= sl[mc[AW-1:0]];
    if (cmd.grad) begin
      pl1[c[AW-1:0]] <= mid;
      pl0[c[AW-1:0]] <= p;
    end
    if (cmd.finish) begin
      ml1[mc[AW-1:0]] <= mmid;
      ml0[mc[AW-1:0]] <= m;
      sl[mc[AW-1:0]] <= sec;
    end
  end

  // counters and pixel window
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      for (int i = 0; i < 6; i++) pw[i] <= '0;
    end else if (cmd.grad) begin
      pw[3] <= pw[0]; pw[4] <= pw[1]; pw[5] <= pw[2];
      pw[0] <= top; pw[1] <= mid; pw[2] <= p;
      if (c + CW'(1) >= w) begin
        col <= '0;
        row <= (r + 12'd1 >= h) ? 12'd0 : r + 12'd1;
      end else begin
        col <= c + CW'(1);
        row <= r;
      end
    end
  end

  // gradients, captured while window still holds prior columns
  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      gx <= (12'(pw[5]) + {3'b0, pw[2], 1'b0} + 12'(p))
          - (12'(pw[3]) + {3'b0, pw[0], 1'b0} + 12'(top));
      gy <= (12'(pw[3]) + {3'b0, pw[4], 1'b0} + 12'(pw[5]))
          - (12'(top) + {3'b0, mid, 1'b0} + 12'(p));
      root <= '0;
      rbit <= 8'h80;
    end else if (cmd.root_go && rbit != 8'd0) begin
      if (16'(root | rbit) * 16'(root | rbit) <= v) root <= root | rbit;
      rbit <= rbit >> 1;
    end
  end

  assign v = 24'(gx) * 24'(gx) + 24'(gy) * 24'(gy);
  assign sat = v >= 24'd65025;
  assign m = sat ? 8'd255 : root;
  assign sec = sector_of(gx, gy);

  // magnitude window, sector delay, result
  logic [7:0] a, b;
  always_comb begin
    case (hold)
      2'd0: begin a = mw[0]; b = mw[2]; end
      2'd1: begin a = mw[3]; b = m; end
      2'd2: begin a = mw[4]; b = mmid; end
      default: begin a = mw[5]; b = mtop; end
    endcase
  end

  assign res_load = cmd.finish && (mc >= CW'(2)) && (r >= 12'd4);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= '0;
      for (int i = 0; i < 6; i++) mw[i] <= '0;
    end else if (cmd.finish) begin
      hold <= sl_rd;
      mw[3] <= mw[0]; mw[4] <= mw[1]; mw[5] <= mw[2];
      mw[0] <= mtop; mw[1] <= mmid; mw[2] <= m;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_value <= (mw[1] < a || mw[1] < b) ? 8'd0 : mw[1];
      res_eor <= (c + CW'(1) == w);
      res_eof <= (c + CW'(1) == w) && (r + 12'd1 == h);
    end
  end
endmodule

>>> sv/sobel_nonmax_edge_thinning.sv
// ----------------------------------------------------------------------------
// sobel_nonmax_edge_thinning
// Sobel gradient magnitude with non-maximum suppression over a pixel stream.
// ----------------------------------------------------------------------------
// channel   | direction | transaction
// pixel     | in        | pixel_valid & !pixel_stall
// result    | out       | result_valid & !result_stall
// config    | in        | APB write, psel & penable & pwrite
//
// A pixel with no gradient passes through accept, read and gradients; one with a
// gradient goes on through 8 root iterations, the done check and the result, so the
// bit-serial root sets how long it takes.
// Reset clears counters and windows; line stores are not cleared.
// A result stalled in the output register holds the next one in ST_OUT.
// ----------------------------------------------------------------------------
`include "sobel_nonmax_edge_thinning_macros.svh"
module sobel_nonmax_edge_thinning import sne_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic [7:0]  pixel,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  edge_value,
  output logic        end_of_row,
  output logic        end_of_frame,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:2]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [10:0] image_width;
  logic [11:0] image_height;
  cmd_t cmd;
  stat_t stat;
  logic in_ready, res_load, out_busy;
  logic [7:0] res_value;
  logic res_eor, res_eof;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width <= pwdata[10:0];
        REG_HEIGHT: image_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end
  assign prdata = (paddr[2] == REG_HEIGHT) ? {20'd0, image_height}
                                          : {21'd0, image_width};

  // output register: busy while a result waits and is stalled
  assign out_busy = result_valid && result_stall;
  assign pixel_stall = !in_ready;

  sne_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(pixel_valid && in_ready),
    .out_busy(out_busy), .stat(stat), .cmd(cmd), .in_ready(in_ready)
  );

  sne_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .pixel(pixel),
    .image_width(image_width), .image_height(image_height),
    .res_load(res_load), .res_value(res_value), .res_eor(res_eor),
    .res_eof(res_eof)
  );

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (res_load) result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
  end
  assign edge_value = res_value;
  assign end_of_row = res_eor;
  assign end_of_frame = res_eof;

  `SNE_ASSERT_IMP(a_no_overwrite, clk, rst, res_load, !out_busy)
  `SNE_ASSERT_IMP(a_eof_has_eor, clk, rst, result_valid && end_of_frame, end_of_row)
  `SNE_ASSERT_NEXT(a_take_blocks, clk, rst, pixel_valid && in_ready, pixel_stall)
endmodule
